// ===== hdl/vector_rotate_axis_angle_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef VECTOR_ROTATE_AXIS_ANGLE_UNIT_MACROS_SVH
`define VECTOR_ROTATE_AXIS_ANGLE_UNIT_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define VRA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define VRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== hdl/vra_pkg.sv =====
// Package with widths, CORDIC constants and helper functions for the rotation unit.
package vra_pkg;
   localparam int TRIG_STAGES = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int STAGE_W = $clog2(ATAN_ENTRIES);
   localparam int VEC_W = 24;
   localparam int AXIS_W = 16;
   localparam int ANG_W = 16;
   localparam int CW = 34;
   localparam int ZW = 34;
   localparam int QW = 17;
   localparam int PW = 44;
   localparam int RW = 64;
   localparam int PIPE_DEPTH = TRIG_STAGES + 6;
   localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
   localparam logic signed [VEC_W-1:0] OUT_MAX = 24'sh7FFFFF;
   localparam logic signed [VEC_W-1:0] OUT_MIN = -24'sh800000;

   typedef logic signed [CW-1:0] cord_type;
   typedef logic signed [ZW-1:0] phase_type;
   typedef logic signed [VEC_W-1:0] vec_type;
   typedef logic signed [AXIS_W-1:0] axis_type;

   // One word moving down the CORDIC chain.
   typedef struct packed {
      logic valid;
      logic fold;
      cord_type x;
      cord_type y;
      phase_type z;
      vec_type vx;
      vec_type vy;
      vec_type vz;
      axis_type ax;
      axis_type ay;
      axis_type az;
   } cell_word_type;

   // Arctangent table in units of 2^-32 turn.
   function automatic phase_type atan_of(input int idx);
      logic [31:0] t;
      begin
         case (idx)
            0: t = 32'h20000000;  1: t = 32'h12E4051D;  2: t = 32'h09FB385B;
            3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
            9: t = 32'h00145F2E;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
            12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
            15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
            18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
            21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
            default: t = 32'h0;
         endcase
         atan_of = phase_type'({2'b00, t});
      end
   endfunction
endpackage

// ===== hdl/vra_cordic_cell.sv =====
// One CORDIC rotation cell: a fixed shift, a table angle and a register.
module vra_cordic_cell (
   input  logic clock,
   input  logic reset,
   input  logic [vra_pkg::STAGE_W-1:0] stage,
   input  vra_pkg::cell_word_type word_in,
   output vra_pkg::cell_word_type word_out
);
   import vra_pkg::*;

   cell_word_type word_ff, word_in_c;
   cord_type dx, dy;
   phase_type ang;

   // Rotate toward zero residual phase; zero counts as positive.
   // The stage index is tied off per cell, so the shift is a fixed wiring.
   always_comb begin
      dx = word_in.y >>> stage;
      dy = word_in.x >>> stage;
      ang = atan_of(int'(stage));
      word_in_c = word_in;
      if (!word_in.z[ZW-1]) begin
         word_in_c.x = word_in.x - dx;
         word_in_c.y = word_in.y + dy;
         word_in_c.z = word_in.z - ang;
      end else begin
         word_in_c.x = word_in.x + dx;
         word_in_c.y = word_in.y - dy;
         word_in_c.z = word_in.z + ang;
      end
   end

   // Valid is control; the rest is payload.
   always_ff @(posedge clock) begin
      word_ff <= word_in_c;
      if (reset) begin
         word_ff.valid <= 1'b0;
      end
   end

   assign word_out = word_ff;
endmodule

// ===== hdl/vra_qmul.sv =====
// Quaternion back end: builds q, forms q*v*conj(q), rounds and saturates.
module vra_qmul (
   input  logic clock,
   input  logic reset,
   input  vra_pkg::cell_word_type word_in,
   output logic out_valid,
   output vra_pkg::vec_type out_x,
   output vra_pkg::vec_type out_y,
   output vra_pkg::vec_type out_z
);
   import vra_pkg::*;

   logic [4:0] v_ff;
   logic signed [QW-1:0] s_ff, c_ff;
   vec_type vx_ff, vy_ff, vz_ff, vx2_ff, vy2_ff, vz2_ff, vx3_ff, vy3_ff, vz3_ff;
   axis_type ax_ff, ay_ff, az_ff;
   logic signed [QW-1:0] c2_ff, qx_ff, qy_ff, qz_ff, qw3_ff;
   logic signed [QW-1:0] qw4_ff, qx4_ff, qy4_ff, qz4_ff;
   logic signed [32:0] mx_ff, my_ff, mz_ff;
   logic signed [PW-1:0] pw_ff, px_ff, py_ff, pz_ff;
   logic signed [RW-1:0] rx_ff, ry_ff, rz_ff;

   logic signed [CW-1:0] xr, yr;
   logic signed [QW-1:0] s_in, c_in;
   logic signed [32:0] rqx, rqy, rqz;

   function automatic vec_type sat(input logic signed [RW-1:0] v);
      logic signed [RW-1:0] r;
      begin
         r = (v + (signed'(RW'(1)) <<< 27)) >>> 28;
         if (r > RW'(signed'(OUT_MAX))) sat = OUT_MAX;
         else if (r < RW'(signed'(OUT_MIN))) sat = OUT_MIN;
         else sat = r[VEC_W-1:0];
      end
   endfunction

   // Round the CORDIC outputs to Q1.14 and undo the range fold.
   always_comb begin
      xr = (word_in.x + CW'(32768)) >>> 16;
      yr = (word_in.y + CW'(32768)) >>> 16;
      if (word_in.fold) begin
         s_in = xr[QW-1:0];
         c_in = -yr[QW-1:0];
      end else begin
         s_in = yr[QW-1:0];
         c_in = xr[QW-1:0];
      end
      rqx = (mx_ff + 33'sd8192) >>> 14;
      rqy = (my_ff + 33'sd8192) >>> 14;
      rqz = (mz_ff + 33'sd8192) >>> 14;
   end

   // Five registered steps: sincos, axis scale, rounding, two products.
   always_ff @(posedge clock) begin
      s_ff <= s_in;  c_ff <= c_in;
      vx_ff <= word_in.vx; vy_ff <= word_in.vy; vz_ff <= word_in.vz;
      ax_ff <= word_in.ax; ay_ff <= word_in.ay; az_ff <= word_in.az;

      mx_ff <= 33'(ax_ff * s_ff);
      my_ff <= 33'(ay_ff * s_ff);
      mz_ff <= 33'(az_ff * s_ff);
      c2_ff <= c_ff;
      vx2_ff <= vx_ff; vy2_ff <= vy_ff; vz2_ff <= vz_ff;

      qx_ff <= rqx[QW-1:0]; qy_ff <= rqy[QW-1:0]; qz_ff <= rqz[QW-1:0];
      qw3_ff <= c2_ff;
      vx3_ff <= vx2_ff; vy3_ff <= vy2_ff; vz3_ff <= vz2_ff;

      pw_ff <= -(PW'(qx_ff) * PW'(vx3_ff)) - PW'(qy_ff) * PW'(vy3_ff)
               - PW'(qz_ff) * PW'(vz3_ff);
      px_ff <= PW'(qw3_ff) * PW'(vx3_ff) + PW'(qy_ff) * PW'(vz3_ff)
               - PW'(qz_ff) * PW'(vy3_ff);
      py_ff <= PW'(qw3_ff) * PW'(vy3_ff) + PW'(qz_ff) * PW'(vx3_ff)
               - PW'(qx_ff) * PW'(vz3_ff);
      pz_ff <= PW'(qw3_ff) * PW'(vz3_ff) + PW'(qx_ff) * PW'(vy3_ff)
               - PW'(qy_ff) * PW'(vx3_ff);
      qw4_ff <= qw3_ff; qx4_ff <= qx_ff; qy4_ff <= qy_ff; qz4_ff <= qz_ff;

      rx_ff <= RW'(px_ff) * RW'(qw4_ff) - RW'(pw_ff) * RW'(qx4_ff)
               - RW'(py_ff) * RW'(qz4_ff) + RW'(pz_ff) * RW'(qy4_ff);
      ry_ff <= RW'(py_ff) * RW'(qw4_ff) - RW'(pw_ff) * RW'(qy4_ff)
               - RW'(pz_ff) * RW'(qx4_ff) + RW'(px_ff) * RW'(qz4_ff);
      rz_ff <= RW'(pz_ff) * RW'(qw4_ff) - RW'(pw_ff) * RW'(qz4_ff)
               - RW'(px_ff) * RW'(qy4_ff) + RW'(py_ff) * RW'(qx4_ff);
   end

   // Valid pipe.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[3:0], word_in.valid};
      end
   end

   // Final rounding and saturation straight off the last product register.
   assign out_valid = v_ff[4];
   assign out_x = sat(rx_ff);
   assign out_y = sat(ry_ff);
   assign out_z = sat(rz_ff);
endmodule

// ===== hdl/vector_rotate_axis_angle_unit.sv =====
// Top level of the axis-angle vector rotation unit.
// The unit takes one word per cycle and never stalls: busy is always low.
// Each word gives exactly one result, shown for one cycle with rsp_valid;
// it passes the entry register, the chain of 16 CORDIC cells and the
// registered steps of the quaternion back end.
// The receiver must take every result in the cycle it appears.
module vector_rotate_axis_angle_unit (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [23:0] req_vec_x,
   input  logic signed [23:0] req_vec_y,
   input  logic signed [23:0] req_vec_z,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   input  logic [15:0] req_angle,
   output logic rsp_valid,
   output logic signed [23:0] rsp_rot_x,
   output logic signed [23:0] rsp_rot_y,
   output logic signed [23:0] rsp_rot_z
);
   import vra_pkg::*;

   cell_word_type chain [0:TRIG_STAGES];
   cell_word_type head_ff, head_in;

   // Entry register: phase setup and range fold.
   always_comb begin
      head_in.valid = start;
      head_in.fold = req_angle[ANG_W-1];
      head_in.z = phase_type'({1'b0, req_angle, 15'b0});
      if (req_angle[ANG_W-1]) begin
         head_in.z = head_in.z - (ZW'(1) <<< 30);
      end
      head_in.x = CORDIC_START;
      head_in.y = '0;
      head_in.vx = req_vec_x; head_in.vy = req_vec_y; head_in.vz = req_vec_z;
      head_in.ax = req_axis_x; head_in.ay = req_axis_y; head_in.az = req_axis_z;
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      if (reset) begin
         head_ff.valid <= 1'b0;
      end
   end

   assign chain[0] = head_ff;

   // Chain of CORDIC cells.
   for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
      vra_cordic_cell u_cell (
         .clock(clock), .reset(reset), .stage(STAGE_W'(g)),
         .word_in(chain[g]), .word_out(chain[g+1])
      );
   end

   vra_qmul u_qmul (
      .clock(clock), .reset(reset), .word_in(chain[TRIG_STAGES]),
      .out_valid(rsp_valid), .out_x(rsp_rot_x), .out_y(rsp_rot_y),
      .out_z(rsp_rot_z)
   );

   assign busy = 1'b0;
endmodule

// ===== hdl/vra_checker.sv =====
// Port checker for the rotation unit and its bind statement.
`include "vector_rotate_axis_angle_unit_macros.svh"
module vra_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   import vra_pkg::*;

   `VRA_ASSERT_IMPL(a_never_busy, clock, reset, 1'b1, !busy)
   `VRA_ASSERT_NEXT(a_idle_after_reset, clock, 1'b0, reset, !rsp_valid)
   `VRA_ASSERT_IMPL(a_no_spurious, clock, reset,
      rsp_valid && !$past(reset, PIPE_DEPTH), $past(start, PIPE_DEPTH))
endmodule

bind vector_rotate_axis_angle_unit vra_checker u_vra_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid)
);
